@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the voice mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define SPMV_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Common form for modules clocked by i_clk with reset i_rst_n.
`define SPMV_ASSERT(name, prop, msg) \
    `SPMV_ASSERT_CLK(name, i_clk, i_rst_n, prop, msg)

`endif

@@ sv/spmv_pkg.sv @@
// ----------------------------------------------------------------------------
// spmv_pkg
// Types and constants shared by the stereo pan mixer voice.
// ----------------------------------------------------------------------------
package spmv_pkg;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MIX   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_VOICE_GAIN    = 3'd0;
    localparam logic [2:0] CFG_PAN_POSITION  = 3'd1;
    localparam logic [2:0] CFG_MASTER_GAIN   = 3'd2;
    localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_LENGTH = 3'd4;

    localparam logic [15:0] GAIN_UNITY   = 16'd16384;
    localparam logic [15:0] PAN_CENTER   = 16'd16384;
    localparam logic [15:0] PAN_FULL     = 16'd32768;

    localparam logic [36:0] SAT_POS_LIMIT = 37'd2147483647;
    localparam logic [36:0] SAT_NEG_LIMIT = 37'd2147483648;
    localparam logic [31:0] SAT_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN       = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SUM,
        ST_ABS,
        ST_SCALE,
        ST_COMB,
        ST_OUT
    } t_state;

    // Stage enables for one arithmetic lane.
    typedef struct packed {
        logic mult_en;
        logic sum_en;
        logic abs_en;
        logic scale_en;
        logic comb_en;
    } t_lane_ctl;

endpackage

@@ sv/spmv_in_if.sv @@
// ----------------------------------------------------------------------------
// spmv_in_if
// Input channel of the voice: operation, sample write data and mix frame.
// ----------------------------------------------------------------------------
interface spmv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [11:0]        sample_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] mix_left;
    logic signed [31:0] mix_right;

    modport source (
        output valid, operation, sample_index, sample_value, mix_left, mix_right,
        input  ready
    );

    modport sink (
        input  valid, operation, sample_index, sample_value, mix_left, mix_right,
        output ready
    );
endinterface

@@ sv/spmv_out_if.sv @@
// ----------------------------------------------------------------------------
// spmv_out_if
// Output channel of the voice: mixed stereo frame and playing status.
// ----------------------------------------------------------------------------
interface spmv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_left;
    logic signed [31:0] out_right;
    logic               voice_playing;

    modport source (
        output valid, out_left, out_right, voice_playing,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right, voice_playing,
        output ready
    );
endinterface

@@ sv/spmv_store.sv @@
// ----------------------------------------------------------------------------
// spmv_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spmv_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/spmv_lane.sv @@
// ----------------------------------------------------------------------------
// spmv_lane
// One output channel: sample times gain-pan, plus shifted base, scaled by
// master gain, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module spmv_lane (
    input  logic                i_clk,
    input  spmv_pkg::t_lane_ctl i_ctl,
    input  logic signed [31:0]  i_sample,
    input  logic [31:0]         i_gain_pan,
    input  logic signed [31:0]  i_base,
    input  logic [15:0]         i_master,
    output logic signed [31:0]  o_result
);

    logic signed [63:0] r_prod;
    logic signed [63:0] r_sum;
    logic [63:0]        r_mag;
    logic               r_neg;
    logic [47:0]        r_plo;
    logic [47:0]        r_phi;
    logic [36:0]        r_q;

    logic signed [64:0] prod_full;
    logic signed [63:0] base_ext;
    logic [48:0]        q_sum;

    assign prod_full = 65'(i_sample) * 65'($signed({1'b0, i_gain_pan}));
    // Base times 2^30, sign extended to the full accumulator width.
    assign base_ext  = {{2{i_base[31]}}, i_base, 30'b0};
    assign q_sum     = {1'b0, r_phi} + 49'(r_plo[47:32]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mult_en) begin
            r_prod <= prod_full[63:0];
        end
        if (i_ctl.sum_en) begin
            r_sum <= base_ext + r_prod;
        end
        if (i_ctl.abs_en) begin
            r_neg <= r_sum[63];
            r_mag <= r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
        end
        if (i_ctl.scale_en) begin
            r_plo <= 48'(r_mag[31:0] * i_master);
            r_phi <= 48'(r_mag[63:32] * i_master);
        end
        if (i_ctl.comb_en) begin
            // Magnitude times master gain over 2^44, rounded down.
            r_q <= q_sum[48:12];
        end
    end

    always_comb begin
        if (r_neg) begin
            o_result = (r_q > spmv_pkg::SAT_NEG_LIMIT) ? spmv_pkg::SAT_MIN
                                                       : (~r_q[31:0] + 32'd1);
        end else begin
            o_result = (r_q > spmv_pkg::SAT_POS_LIMIT) ? spmv_pkg::SAT_MAX
                                                       : r_q[31:0];
        end
    end

endmodule

@@ sv/stereo_pan_mixer_voice.sv @@
// ----------------------------------------------------------------------------
// stereo_pan_mixer_voice
// One playback voice mixing a stored mono sample into a stereo stream.
// ----------------------------------------------------------------------------
// Usage: beats arrive on i_voice_in with an operation code. A write beat
// stores one sample word (indexes beyond the store are dropped), a start
// beat rewinds the voice and sets it playing; both give no result. A mix
// beat gives exactly one beat on o_voice_out with the mixed left/right
// frame and the playing status after that frame.
// A mix beat that plays a sample passes through the registered sample
// memory read, the sample by gain-pan multiply, the base add, the
// magnitude, the master gain partial products and their combination, with
// the saturation feeding the result register. A mix beat that passes the
// frame through goes from its registered payload to the result register.
// The next beat is taken the cycle after the result is registered, so the
// voice takes no new beat while a mix is in flight; left and right run in
// parallel lanes.
// Reset stops the voice, rewinds the cursor and loads the register defaults;
// the sample memory is not cleared. When the receiver stalls, the result
// waits in the output register; a following beat is still accepted and its
// result waits in the last stage until the register frees.
// Configuration writes on i_cfg_* take effect at once; the user must make
// them only while the voice is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_pan_mixer_voice #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    spmv_in_if.sink       i_voice_in,
    spmv_out_if.source    o_voice_out
);

    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
    localparam int WIDE = 22;

    // Configuration registers.
    logic [15:0] r_voice_gain;
    logic [15:0] r_pan_position;
    logic [15:0] r_master_gain;
    logic        r_loop_enable;
    logic [12:0] r_sample_length;

    // Voice state.
    logic [CW-1:0] r_cursor;
    logic          r_playing;

    spmv_pkg::t_state r_state;
    spmv_pkg::t_state n_state;
    spmv_pkg::t_lane_ctl lane_ctl;

    // Per-frame payload.
    logic signed [31:0] r_base_l;
    logic signed [31:0] r_base_r;
    logic [31:0]        r_gp_l;
    logic [31:0]        r_gp_r;
    logic               r_pass;
    logic               r_play_out;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_left;
    logic signed [31:0] r_out_right;
    logic               r_out_play;

    logic               in_accept;
    logic               is_write;
    logic               is_mix;
    logic               is_start;
    logic [WIDE-1:0]    depth_w;
    logic [WIDE-1:0]    len_w;
    logic [WIDE-1:0]    len_eff;
    logic [WIDE-1:0]    cursor_w;
    logic [WIDE-1:0]    idx_w;
    logic               at_end;
    logic               wrap;
    logic               play_now;
    logic [CW-1:0]      cursor_base;
    logic [15:0]        pan_clamp;
    logic [15:0]        pan_left;
    logic               mem_we;
    logic               mem_re;
    logic [31:0]        mem_rdata;
    logic signed [31:0] lane_l;
    logic signed [31:0] lane_r;
    logic               out_load;

    assign in_accept = i_voice_in.valid && i_voice_in.ready;
    assign is_write  = in_accept && (i_voice_in.operation == spmv_pkg::OP_WRITE);
    assign is_mix    = in_accept && (i_voice_in.operation == spmv_pkg::OP_MIX);
    assign is_start  = in_accept && (i_voice_in.operation == spmv_pkg::OP_START);

    assign depth_w  = WIDE'(SAMPLE_DEPTH);
    assign len_w    = WIDE'(r_sample_length);
    assign len_eff  = (len_w > depth_w) ? depth_w : len_w;
    assign cursor_w = WIDE'(r_cursor);
    assign idx_w    = WIDE'(i_voice_in.sample_index);

    // End of sample: wrap when looping over a non-empty sample, else stop.
    assign at_end      = r_playing && (cursor_w >= len_eff);
    assign wrap        = at_end && r_loop_enable && (len_eff != '0);
    assign play_now    = r_playing && !(at_end && !wrap);
    assign cursor_base = wrap ? '0 : r_cursor;

    assign pan_clamp = (r_pan_position > spmv_pkg::PAN_FULL) ? spmv_pkg::PAN_FULL
                                                             : r_pan_position;
    assign pan_left  = spmv_pkg::PAN_FULL - pan_clamp;

    assign mem_we = is_write && (idx_w < depth_w);
    assign mem_re = is_mix && play_now;

    spmv_store #(
        .DEPTH (SAMPLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx_w[AW-1:0]),
        .i_wdata (i_voice_in.sample_value),
        .i_re    (mem_re),
        .i_raddr (cursor_base[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    spmv_lane u_lane_l (
        .i_clk      (i_clk),
        .i_ctl      (lane_ctl),
        .i_sample   ($signed(mem_rdata)),
        .i_gain_pan (r_gp_l),
        .i_base     (r_base_l),
        .i_master   (r_master_gain),
        .o_result   (lane_l)
    );

    spmv_lane u_lane_r (
        .i_clk      (i_clk),
        .i_ctl      (lane_ctl),
        .i_sample   ($signed(mem_rdata)),
        .i_gain_pan (r_gp_r),
        .i_base     (r_base_r),
        .i_master   (r_master_gain),
        .o_result   (lane_r)
    );

    assign out_load = (r_state == spmv_pkg::ST_OUT) && (!r_out_valid || o_voice_out.ready);

    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        case (r_state)
            spmv_pkg::ST_IDLE: begin
                if (is_mix) begin
                    n_state = play_now ? spmv_pkg::ST_MULT : spmv_pkg::ST_OUT;
                end
            end
            spmv_pkg::ST_MULT: begin
                lane_ctl.mult_en = 1'b1;
                n_state = spmv_pkg::ST_SUM;
            end
            spmv_pkg::ST_SUM: begin
                lane_ctl.sum_en = 1'b1;
                n_state = spmv_pkg::ST_ABS;
            end
            spmv_pkg::ST_ABS: begin
                lane_ctl.abs_en = 1'b1;
                n_state = spmv_pkg::ST_SCALE;
            end
            spmv_pkg::ST_SCALE: begin
                lane_ctl.scale_en = 1'b1;
                n_state = spmv_pkg::ST_COMB;
            end
            spmv_pkg::ST_COMB: begin
                lane_ctl.comb_en = 1'b1;
                n_state = spmv_pkg::ST_OUT;
            end
            spmv_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = spmv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spmv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_gain    <= spmv_pkg::GAIN_UNITY;
            r_pan_position  <= spmv_pkg::PAN_CENTER;
            r_master_gain   <= spmv_pkg::GAIN_UNITY;
            r_loop_enable   <= 1'b0;
            r_sample_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spmv_pkg::CFG_VOICE_GAIN:    r_voice_gain    <= i_cfg_data;
                spmv_pkg::CFG_PAN_POSITION:  r_pan_position  <= i_cfg_data;
                spmv_pkg::CFG_MASTER_GAIN:   r_master_gain   <= i_cfg_data;
                spmv_pkg::CFG_LOOP_ENABLE:   r_loop_enable   <= i_cfg_data[0];
                spmv_pkg::CFG_SAMPLE_LENGTH: r_sample_length <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_playing <= 1'b0;
        end else if (is_start) begin
            r_cursor  <= '0;
            r_playing <= 1'b1;
        end else if (is_mix) begin
            if (play_now) begin
                r_cursor <= cursor_base + CW'(1);
            end else begin
                r_playing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mix) begin
            r_base_l   <= i_voice_in.mix_left;
            r_base_r   <= i_voice_in.mix_right;
            r_gp_l     <= 32'(r_voice_gain) * 32'(pan_left);
            r_gp_r     <= 32'(r_voice_gain) * 32'(pan_clamp);
            r_pass     <= !play_now;
            r_play_out <= play_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_voice_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left  <= r_pass ? r_base_l : lane_l;
            r_out_right <= r_pass ? r_base_r : lane_r;
            r_out_play  <= r_play_out;
        end
    end

    assign i_voice_in.ready        = (r_state == spmv_pkg::ST_IDLE);
    assign o_voice_out.valid         = r_out_valid;
    assign o_voice_out.out_left      = r_out_left;
    assign o_voice_out.out_right     = r_out_right;
    assign o_voice_out.voice_playing = r_out_play;

    // A mix beat holds off further input until its result is registered.
    `SPMV_ASSERT(a_mix_blocks_input,
        is_mix |=> !i_voice_in.ready,
        "input accepted while a mix beat is in flight")

    // The cursor never runs past the end of the store.
    `SPMV_ASSERT(a_cursor_in_range,
        cursor_w <= depth_w,
        "play cursor beyond sample store")

    // A pass-through frame always reports the voice as stopped.
    `SPMV_ASSERT(a_pass_not_playing,
        (r_state == spmv_pkg::ST_OUT) && r_pass |-> !r_play_out,
        "pass-through frame flagged as playing")

    // A new result only appears from the final stage.
    `SPMV_ASSERT(a_result_from_out,
        $rose(r_out_valid) |-> $past(r_state) == spmv_pkg::ST_OUT,
        "result registered outside the output stage")

endmodule

@@ tb/tb_stereo_pan_mixer_voice.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_pan_mixer_voice
// Self-checking testbench for one stereo pan mixer voice. A short table of
// directed beats is walked first, and then several random phases run under
// different idle and stall patterns. A shadow copy of the voice state, or a
// directed row, predicts each frame; each result beat is compared with it.
// ----------------------------------------------------------------------------
module tb_stereo_pan_mixer_voice;

    localparam int         STORE_WORDS     = 4096;
    localparam int         CYCLE_LIMIT     = 1_000_000;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         BEATS_PER_PHASE = 225;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] sample_index;
        logic [31:0] sample_value;
        logic [31:0] mix_left;
        logic [31:0] mix_right;
    } t_voice_beat;

    typedef struct packed {
        logic [31:0] out_left;
        logic [31:0] out_right;
        logic        voice_playing;
    } t_mixed_frame;

    typedef struct {
        t_row_kind    kind;
        logic [2:0]   cfg_index;
        logic [15:0]  cfg_data;
        t_voice_beat  beat;
        bit           typed;
        t_mixed_frame frame;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    spmv_in_if  voice_in();
    spmv_out_if voice_out();

    stereo_pan_mixer_voice u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_voice_in  (voice_in),
        .o_voice_out (voice_out)
    );

    // Shadow copy of the voice: sample store, cursor, flag and registers.
    logic [31:0]  shadow_store [STORE_WORDS];
    bit           store_written [STORE_WORDS];
    logic [12:0]  play_pos;
    bit           is_playing;
    logic [15:0]  gain_reg;
    logic [15:0]  pan_reg;
    logic [15:0]  master_reg;
    logic         loop_reg;
    logic [12:0]  length_reg;

    t_mixed_frame pending_frames[$];
    t_stim_row    stim_rows[$];
    t_idle_mode   idle_mode   = IDLE_NONE;
    int           fail_count  = 0;
    int           cycle_count = 0;
    int           hold_count  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver side. In hold mode it refuses results for a long stretch so
    // that the voice fills up and stops taking input beats.
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
            voice_out.ready <= 1'b0;
            hold_count      <= hold_count + 1;
        end else begin
            if (idle_mode != IDLE_HOLD) begin
                hold_count <= 0;
            end
            case (idle_mode)
                IDLE_RECV: voice_out.ready <= ($urandom_range(99) >= 80);
                IDLE_BOTH: voice_out.ready <= ($urandom_range(99) >= 14);
                default:   voice_out.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : p_frame_check
        t_mixed_frame want;
        if (i_rst_n && voice_out.valid && voice_out.ready) begin
            if (pending_frames.size() == 0) begin
                $error("result beat with no mix pending: left %h right %h",
                       voice_out.out_left, voice_out.out_right);
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                if (voice_out.out_left !== want.out_left) begin
                    $error("out_left: expected %h, actual %h",
                           want.out_left, voice_out.out_left);
                    fail_count++;
                end
                if (voice_out.out_right !== want.out_right) begin
                    $error("out_right: expected %h, actual %h",
                           want.out_right, voice_out.out_right);
                    fail_count++;
                end
                if (voice_out.voice_playing !== want.voice_playing) begin
                    $error("voice_playing: expected %b, actual %b",
                           want.voice_playing, voice_out.voice_playing);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return spmv_pkg::SAT_MAX;
            1:       return spmv_pkg::SAT_MIN;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [12:0] effective_length();
        return (length_reg > STORE_WORDS) ? 13'(STORE_WORDS) : length_reg;
    endfunction

    // Store word that the next mix beat would read, or -1 if it reads none.
    function automatic int next_read_word();
        if (!is_playing) begin
            return -1;
        end
        if (play_pos >= effective_length()) begin
            return (loop_reg && effective_length() != 0) ? 0 : -1;
        end
        return int'(play_pos);
    endfunction

    // Master gain scaling: truncate toward zero after the 2^44 shift, then
    // saturate to signed 32 bits.
    function automatic logic [31:0] scale_to_output(input logic signed [63:0] acc,
                                                    input logic [15:0] gain);
        logic [63:0] mag;
        logic [79:0] quot;
        mag  = (acc < 0) ? -acc : acc;
        quot = (80'(mag) * 80'(gain)) >> 44;
        if (acc < 0) begin
            return (quot >= 80'd2147483648) ? spmv_pkg::SAT_MIN : -quot[31:0];
        end
        return (quot > 80'd2147483647) ? spmv_pkg::SAT_MAX : quot[31:0];
    endfunction

    task automatic advance_voice(input t_voice_beat b);
        logic [15:0]        pan_eff;
        logic signed [63:0] sample_s;
        logic signed [63:0] base_l;
        logic signed [63:0] base_r;
        logic signed [63:0] weight_l;
        logic signed [63:0] weight_r;
        t_mixed_frame       f;
        case (b.operation)
            spmv_pkg::OP_WRITE: begin
                shadow_store[b.sample_index]  = b.sample_value;
                store_written[b.sample_index] = 1'b1;
            end
            spmv_pkg::OP_START: begin
                play_pos   = '0;
                is_playing = 1'b1;
            end
            spmv_pkg::OP_MIX: begin
                if (is_playing && play_pos >= effective_length()) begin
                    if (loop_reg && effective_length() != 0) begin
                        play_pos = '0;
                    end else begin
                        is_playing = 1'b0;
                    end
                end
                f.out_left      = b.mix_left;
                f.out_right     = b.mix_right;
                f.voice_playing = is_playing;
                if (is_playing) begin
                    sample_s      = $signed(shadow_store[play_pos[11:0]]);
                    pan_eff       = (pan_reg > spmv_pkg::PAN_FULL) ? spmv_pkg::PAN_FULL
                                                                   : pan_reg;
                    weight_l      = 64'(gain_reg) * 64'(spmv_pkg::PAN_FULL - pan_eff);
                    weight_r      = 64'(gain_reg) * 64'(pan_eff);
                    base_l        = $signed(b.mix_left);
                    base_r        = $signed(b.mix_right);
                    f.out_left    = scale_to_output(base_l * 64'sd1073741824
                                                    + sample_s * weight_l, master_reg);
                    f.out_right   = scale_to_output(base_r * 64'sd1073741824
                                                    + sample_s * weight_r, master_reg);
                    play_pos      = play_pos + 13'd1;
                end
                pending_frames = {pending_frames, f};
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_beat(input t_voice_beat b);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 80 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        while ($urandom_range(99) < idle_pct) begin
            voice_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        voice_in.valid        <= 1'b1;
        voice_in.operation    <= b.operation;
        voice_in.sample_index <= b.sample_index;
        voice_in.sample_value <= b.sample_value;
        voice_in.mix_left     <= b.mix_left;
        voice_in.mix_right    <= b.mix_right;
        do @(posedge i_clk); while (voice_in.ready !== 1'b1);
        advance_voice(b);
    endtask

    // Stops offering beats and waits until every mixed frame is back, plus a
    // settling wait for a write or start beat still in flight.
    task automatic drain_voice();
        voice_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (index)
            spmv_pkg::CFG_VOICE_GAIN:    gain_reg   = data;
            spmv_pkg::CFG_PAN_POSITION:  pan_reg    = data;
            spmv_pkg::CFG_MASTER_GAIN:   master_reg = data;
            spmv_pkg::CFG_LOOP_ENABLE:   loop_reg   = data[0];
            spmv_pkg::CFG_SAMPLE_LENGTH: length_reg = data[12:0];
            default: begin
            end
        endcase
    endtask

    function automatic t_stim_row beat_row(input logic [1:0] op, input logic [11:0] index,
                                           input logic [31:0] value, input logic [31:0] left,
                                           input logic [31:0] right);
        t_stim_row r;
        r.kind      = ROW_BEAT;
        r.cfg_index = '0;
        r.cfg_data  = '0;
        r.beat      = t_voice_beat'{op, index, value, left, right};
        r.typed     = 1'b0;
        r.frame     = '0;
        return r;
    endfunction

    function automatic t_stim_row mix_row(input logic [31:0] left, input logic [31:0] right,
                                          input bit typed, input t_mixed_frame frame);
        t_stim_row r;
        r       = beat_row(spmv_pkg::OP_MIX, 12'd0, 32'd0, left, right);
        r.typed = typed;
        r.frame = frame;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] index, input logic [15:0] data);
        t_stim_row r;
        r           = beat_row(spmv_pkg::OP_WRITE, 12'd0, 32'd0, 32'd0, 32'd0);
        r.kind      = ROW_CFG;
        r.cfg_index = index;
        r.cfg_data  = data;
        return r;
    endfunction

    function automatic void add_row(input t_stim_row r);
        stim_rows = {stim_rows, r};
    endfunction

    initial begin : p_stimulus
        t_voice_beat b;
        int          rd;
        int          pick;

        voice_in.valid        = 1'b0;
        voice_in.operation    = spmv_pkg::OP_WRITE;
        voice_in.sample_index = '0;
        voice_in.sample_value = '0;
        voice_in.mix_left     = '0;
        voice_in.mix_right    = '0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = spmv_pkg::CFG_VOICE_GAIN;
        i_cfg_data            = '0;
        i_rst_n               = 1'b0;
        play_pos              = '0;
        is_playing            = 1'b0;
        gain_reg              = spmv_pkg::GAIN_UNITY;
        pan_reg               = spmv_pkg::PAN_CENTER;
        master_reg            = spmv_pkg::GAIN_UNITY;
        loop_reg              = 1'b0;
        length_reg            = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stopped after reset, unknown operation, store extremes, empty sample.
        add_row(mix_row(spmv_pkg::SAT_MAX, spmv_pkg::SAT_MIN, 1,
                        t_mixed_frame'{spmv_pkg::SAT_MAX, spmv_pkg::SAT_MIN, 1'b0}));
        add_row(beat_row(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
        add_row(beat_row(spmv_pkg::OP_WRITE, 12'd0, spmv_pkg::SAT_MAX, 32'd0, 32'd0));
        add_row(beat_row(spmv_pkg::OP_WRITE, 12'hFFF, spmv_pkg::SAT_MIN, 32'd0, 32'd0));
        add_row(beat_row(spmv_pkg::OP_WRITE, 12'd1, spmv_pkg::SAT_MIN, 32'd0, 32'd0));
        add_row(beat_row(spmv_pkg::OP_START, 12'd0, 32'd0, 32'd0, 32'd0));
        add_row(mix_row(32'h1234_5678, 32'hFFFF_FFFF, 1,
                        t_mixed_frame'{32'h1234_5678, 32'hFFFF_FFFF, 1'b0}));
        // Full gains and hard left pan saturate both ways, then the sample ends.
        add_row(cfg_row(spmv_pkg::CFG_SAMPLE_LENGTH, 16'd2));
        add_row(cfg_row(spmv_pkg::CFG_VOICE_GAIN, 16'hFFFF));
        add_row(cfg_row(spmv_pkg::CFG_PAN_POSITION, 16'd0));
        add_row(cfg_row(spmv_pkg::CFG_MASTER_GAIN, 16'hFFFF));
        add_row(beat_row(spmv_pkg::OP_START, 12'd0, 32'd0, 32'd0, 32'd0));
        add_row(mix_row(spmv_pkg::SAT_MAX, spmv_pkg::SAT_MIN, 1,
                        t_mixed_frame'{spmv_pkg::SAT_MAX, spmv_pkg::SAT_MIN, 1'b1}));
        add_row(mix_row(spmv_pkg::SAT_MIN, spmv_pkg::SAT_MAX, 1,
                        t_mixed_frame'{spmv_pkg::SAT_MIN, spmv_pkg::SAT_MAX, 1'b1}));
        add_row(mix_row(32'd0, 32'd0, 1, t_mixed_frame'{32'd0, 32'd0, 1'b0}));
        // One-word loop with the pan register beyond full right.
        add_row(cfg_row(spmv_pkg::CFG_LOOP_ENABLE, 16'd1));
        add_row(cfg_row(spmv_pkg::CFG_SAMPLE_LENGTH, 16'd1));
        add_row(cfg_row(spmv_pkg::CFG_PAN_POSITION, 16'hFFFF));
        add_row(cfg_row(spmv_pkg::CFG_VOICE_GAIN, spmv_pkg::GAIN_UNITY));
        add_row(cfg_row(spmv_pkg::CFG_MASTER_GAIN, spmv_pkg::GAIN_UNITY));
        add_row(beat_row(spmv_pkg::OP_START, 12'd0, 32'd0, 32'd0, 32'd0));
        add_row(mix_row(32'd0, 32'd0, 0, '0));
        add_row(mix_row(32'd1000, -32'sd1000, 0, '0));
        add_row(mix_row(-32'sd5, 32'd5, 0, '0));
        add_row(cfg_row(spmv_pkg::CFG_MASTER_GAIN, 16'd0));
        add_row(mix_row(spmv_pkg::SAT_MAX, spmv_pkg::SAT_MIN, 1,
                        t_mixed_frame'{32'd0, 32'd0, 1'b1}));
        // A looping voice with nothing to play still stops.
        add_row(cfg_row(spmv_pkg::CFG_SAMPLE_LENGTH, 16'd0));
        add_row(mix_row(32'hFFFF_FFFF, 32'd1, 1,
                        t_mixed_frame'{32'hFFFF_FFFF, 32'd1, 1'b0}));
        // Length beyond the store, zero voice gain, then a centered pan.
        add_row(cfg_row(spmv_pkg::CFG_MASTER_GAIN, spmv_pkg::GAIN_UNITY));
        add_row(cfg_row(spmv_pkg::CFG_VOICE_GAIN, 16'd0));
        add_row(cfg_row(spmv_pkg::CFG_SAMPLE_LENGTH, 16'd8191));
        add_row(cfg_row(spmv_pkg::CFG_LOOP_ENABLE, 16'd0));
        add_row(cfg_row(spmv_pkg::CFG_PAN_POSITION, spmv_pkg::PAN_FULL));
        add_row(beat_row(spmv_pkg::OP_START, 12'd0, 32'd0, 32'd0, 32'd0));
        add_row(mix_row(32'd1, 32'hFFFF_FFFF, 1,
                        t_mixed_frame'{32'd1, 32'hFFFF_FFFF, 1'b1}));
        add_row(cfg_row(spmv_pkg::CFG_VOICE_GAIN, 16'hFFFF));
        add_row(cfg_row(spmv_pkg::CFG_PAN_POSITION, spmv_pkg::PAN_CENTER));
        add_row(mix_row(32'hAAAA_AAAA, 32'h5555_5555, 0, '0));
        add_row(beat_row(spmv_pkg::OP_WRITE, 12'd2, 32'h5A5A_5A5A, 32'd0, 32'd0));
        add_row(mix_row(32'h5555_5555, 32'hAAAA_AAAA, 0, '0));

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_CFG) begin
                drain_voice();
                write_register(stim_rows[k].cfg_index, stim_rows[k].cfg_data);
            end else begin
                send_beat(stim_rows[k].beat);
                if (stim_rows[k].typed) begin
                    pending_frames[$] = stim_rows[k].frame;
                end
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_voice();
            case (ph % 4)
                0:       idle_mode <= (ph == 4) ? IDLE_HOLD : IDLE_NONE;
                1:       idle_mode <= IDLE_SEND;
                2:       idle_mode <= IDLE_RECV;
                default: idle_mode <= IDLE_BOTH;
            endcase

            case ($urandom_range(3))
                0:       write_register(spmv_pkg::CFG_VOICE_GAIN, 16'd0);
                1:       write_register(spmv_pkg::CFG_VOICE_GAIN, 16'hFFFF);
                2:       write_register(spmv_pkg::CFG_VOICE_GAIN, spmv_pkg::GAIN_UNITY);
                default: write_register(spmv_pkg::CFG_VOICE_GAIN, 16'($urandom));
            endcase
            case ($urandom_range(4))
                0:       write_register(spmv_pkg::CFG_PAN_POSITION, 16'd0);
                1:       write_register(spmv_pkg::CFG_PAN_POSITION, spmv_pkg::PAN_FULL);
                2:       write_register(spmv_pkg::CFG_PAN_POSITION, spmv_pkg::PAN_CENTER);
                3:       write_register(spmv_pkg::CFG_PAN_POSITION,
                                        16'($urandom_range(32768)));
                default: write_register(spmv_pkg::CFG_PAN_POSITION, 16'($urandom));
            endcase
            case ($urandom_range(3))
                0:       write_register(spmv_pkg::CFG_MASTER_GAIN, 16'd0);
                1:       write_register(spmv_pkg::CFG_MASTER_GAIN, 16'hFFFF);
                2:       write_register(spmv_pkg::CFG_MASTER_GAIN, spmv_pkg::GAIN_UNITY);
                default: write_register(spmv_pkg::CFG_MASTER_GAIN, 16'($urandom));
            endcase
            write_register(spmv_pkg::CFG_LOOP_ENABLE, 16'($urandom_range(1)));
            pick = $urandom_range(9);
            if (pick == 0) begin
                write_register(spmv_pkg::CFG_SAMPLE_LENGTH, 16'd0);
            end else if (pick < 5) begin
                write_register(spmv_pkg::CFG_SAMPLE_LENGTH, 16'($urandom_range(8, 1)));
            end else if (pick < 8) begin
                write_register(spmv_pkg::CFG_SAMPLE_LENGTH, 16'($urandom_range(64, 9)));
            end else if (pick == 8) begin
                write_register(spmv_pkg::CFG_SAMPLE_LENGTH, 16'(STORE_WORDS));
            end else begin
                write_register(spmv_pkg::CFG_SAMPLE_LENGTH,
                               16'($urandom_range(8191, STORE_WORDS + 1)));
            end

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(199) == 0) begin
                    drain_voice();
                end
                pick           = $urandom_range(99);
                b.sample_index = ($urandom_range(3) == 0) ? 12'($urandom)
                                                          : 12'($urandom_range(63));
                b.sample_value = rand_word();
                b.mix_left     = rand_word();
                b.mix_right    = rand_word();
                if (pick < 3) begin
                    b.operation = OP_UNUSED;
                end else if (pick < 25) begin
                    b.operation = spmv_pkg::OP_WRITE;
                end else if (pick < 32) begin
                    b.operation = spmv_pkg::OP_START;
                end else begin
                    b.operation = spmv_pkg::OP_MIX;
                    // The voice must never read a word that was not written.
                    rd = next_read_word();
                    if (rd >= 0 && !store_written[rd]) begin
                        send_beat(t_voice_beat'{spmv_pkg::OP_WRITE, 12'(rd), rand_word(),
                                                rand_word(), rand_word()});
                    end
                end
                send_beat(b);
            end
        end

        drain_voice();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/spmv_pkg.sv
sv/spmv_in_if.sv
sv/spmv_out_if.sv
sv/spmv_store.sv
sv/spmv_lane.sv
sv/stereo_pan_mixer_voice.sv
tb/tb_stereo_pan_mixer_voice.sv
